@@ sv/oriented_rect_overlap_test_macros.svh @@
// Assertion macros for the rectangle overlap test
`ifndef ORIENTED_RECT_OVERLAP_TEST_MACROS_SVH
`define ORIENTED_RECT_OVERLAP_TEST_MACROS_SVH

// Check a condition in the same cycle as its trigger
`define ORT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a condition in the cycle after its trigger
`define ORT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/ort_pkg.sv @@
package ort_pkg;

	localparam int SIZE_BITS      = 20;
	localparam int COORD_BITS_DEF = 24;
	localparam int ANGLE_BITS_DEF = 16;
	localparam int PHASE_BITS     = 32;
	localparam int CORDIC_STEPS   = 16;
	localparam int CX_BITS        = 34;
	localparam int CZ_BITS        = 33;
	localparam int TRIG_BITS      = 16;
	localparam int TRIG_MAX       = 32767;
	localparam int ROUND_HALF     = 16384;

	typedef logic signed [CX_BITS-1:0]   cx_t;
	typedef logic signed [CZ_BITS-1:0]   cz_t;
	typedef logic signed [TRIG_BITS-1:0] trig_t;

	localparam cx_t CORDIC_GAIN = 34'sd652032874;

	// Arctangent of 2^-i in 1/2^32 turns
	localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861
	};

	typedef struct packed {
		cx_t x;
		cx_t y;
		cz_t z;
	} cordic_t;

	typedef struct packed {
		trig_t c;
		trig_t s;
	} sincos_t;

	// One rotation step toward zero residual angle
	function automatic cordic_t cordic_step(cordic_t v, int unsigned i);
		cordic_t r;
		cx_t     xs;
		cx_t     ys;
		xs = v.x >>> i;
		ys = v.y >>> i;
		if (!v.z[CZ_BITS-1]) begin
			r.x = v.x - ys;
			r.y = v.y + xs;
			r.z = v.z - cz_t'({1'b0, ATAN_TURNS[i]});
		end else begin
			r.x = v.x + ys;
			r.y = v.y - xs;
			r.z = v.z + cz_t'({1'b0, ATAN_TURNS[i]});
		end
		return r;
	endfunction

	// Round half up from Q4.30 to Q1.15 and saturate
	function automatic trig_t to_q15(cx_t v);
		cx_t t;
		t = (v + cx_t'(ROUND_HALF)) >>> 15;
		if (t > cx_t'(TRIG_MAX))
			return trig_t'(TRIG_MAX);
		if (t < -cx_t'(TRIG_MAX))
			return -trig_t'(TRIG_MAX);
		return t[TRIG_BITS-1:0];
	endfunction

	// Fold the quadrant back in by swaps and negations
	function automatic sincos_t apply_quad(logic [1:0] q, trig_t c, trig_t s);
		sincos_t r;
		case (q)
			2'd0: begin r.c = c;  r.s = s;  end
			2'd1: begin r.c = -s; r.s = c;  end
			2'd2: begin r.c = -c; r.s = -s; end
			default: begin r.c = s; r.s = -c; end
		endcase
		return r;
	endfunction

endpackage

@@ sv/oriented_rect_overlap_test.sv @@
// Oriented rectangle overlap test, one rectangle pair per request.
// Input channel: in_valid / in_ready carry rectangles A and B (corner, size,
// angle). Output channel: out_valid / out_ready carry colliding, which is 1
// unless an edge axis of either rectangle separates the two rectangles.
// There are 14 register stages: input prep, 8 CORDIC stages of two steps
// each, trig rounding, cross products, extent products, extent sums, compare.
// Throughput: one request per cycle until a stalled receiver fills the
// pipeline; the sine/cosine CORDIC is fully unrolled into stages, so no
// unit is shared between requests.
// Each stage has its own valid bit and loads whenever it is empty or the
// stage after it moves, so bubbles close up and a stalled receiver only
// holds the stages that are full. With out_ready low the result holds and
// requests keep entering until the pipeline is full.
// Reset clears all valid bits; the pipeline is empty and in_ready is high.
`include "oriented_rect_overlap_test_macros.svh"

module oriented_rect_overlap_test #(
	parameter int COORD_BITS = ort_pkg::COORD_BITS_DEF,
	parameter int ANGLE_BITS = ort_pkg::ANGLE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [COORD_BITS-1:0]     a_x,
	input  logic signed [COORD_BITS-1:0]     a_y,
	input  logic [ort_pkg::SIZE_BITS-1:0]    a_w,
	input  logic [ort_pkg::SIZE_BITS-1:0]    a_h,
	input  logic [ANGLE_BITS-1:0]            a_angle,
	input  logic signed [COORD_BITS-1:0]     b_x,
	input  logic signed [COORD_BITS-1:0]     b_y,
	input  logic [ort_pkg::SIZE_BITS-1:0]    b_w,
	input  logic [ort_pkg::SIZE_BITS-1:0]    b_h,
	input  logic [ANGLE_BITS-1:0]            b_angle,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             colliding
);
	import ort_pkg::*;

	localparam int CORD_STG = CORDIC_STEPS / 2;
	localparam int S_TRIG   = CORD_STG + 2;
	localparam int S_PROD   = S_TRIG + 1;
	localparam int S_MAG    = S_PROD + 1;
	localparam int S_SUM    = S_MAG + 1;
	localparam int NSTG     = S_SUM + 1;
	localparam int C2W      = ((COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS) + 2;
	localparam int DW       = C2W + 1;
	localparam int KW       = DW + TRIG_BITS + 1;
	localparam int TW       = 2 * TRIG_BITS + 1;
	localparam int MW       = TW - 1;
	localparam int RW       = SIZE_BITS + MW;
	localparam int SW       = RW + 2;
	localparam int CMPW     = ((KW + 15 > SW) ? KW + 15 : SW) + 1;

	typedef logic signed [DW-1:0]   diff_t;
	typedef logic signed [KW-1:0]   dk_t;
	typedef logic signed [TW-1:0]   tw_t;
	typedef logic [SIZE_BITS-1:0]   size_t;
	typedef logic [RW-1:0]          ext_t;

	// Handshake: a stage loads when empty or when its successor moves
	logic [NSTG:1]   vld_s;
	logic [NSTG+1:1] en;

	always_comb begin
		en[NSTG+1] = out_ready;
		for (int j = NSTG; j >= 1; j--)
			en[j] = !vld_s[j] || en[j+1];
	end

	assign in_ready  = en[1];
	assign out_valid = vld_s[NSTG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[1])
				vld_s[1] <= in_valid;
			for (int j = 2; j <= NSTG; j++)
				if (en[j])
					vld_s[j] <= vld_s[j-1];
		end
	end

	// Stages 1 to CORD_STG+1: CORDIC state plus carried geometry
	cordic_t    cor_s  [1:CORD_STG+1][2];
	logic [1:0] quad_s [1:CORD_STG+1][2];
	size_t      w_s    [1:CORD_STG+1][2];
	size_t      h_s    [1:CORD_STG+1][2];
	diff_t      dx_s   [1:CORD_STG+1];
	diff_t      dy_s   [1:CORD_STG+1];

	// Stage 1: phase split, CORDIC seed, doubled center differences
	logic [PHASE_BITS-1:0] phase_c [2];
	diff_t                 dx_c;
	diff_t                 dy_c;

	always_comb begin
		phase_c[0] = {a_angle, {(PHASE_BITS-ANGLE_BITS){1'b0}}};
		phase_c[1] = {b_angle, {(PHASE_BITS-ANGLE_BITS){1'b0}}};
		dx_c = (DW'(b_x) <<< 1) + DW'($signed({1'b0, b_w}))
			- (DW'(a_x) <<< 1) - DW'($signed({1'b0, a_w}));
		dy_c = (DW'(b_y) <<< 1) + DW'($signed({1'b0, b_h}))
			- (DW'(a_y) <<< 1) - DW'($signed({1'b0, a_h}));
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int r = 0; r < 2; r++) begin
				cor_s[1][r].x <= CORDIC_GAIN;
				cor_s[1][r].y <= '0;
				cor_s[1][r].z <= cz_t'(phase_c[r][PHASE_BITS-3:0]);
				quad_s[1][r]  <= phase_c[r][PHASE_BITS-1:PHASE_BITS-2];
			end
			w_s[1][0] <= a_w;
			h_s[1][0] <= a_h;
			w_s[1][1] <= b_w;
			h_s[1][1] <= b_h;
			dx_s[1]   <= dx_c;
			dy_s[1]   <= dy_c;
		end
	end

	// CORDIC stages: two rotation steps each
	for (genvar k = 0; k < CORD_STG; k++) begin : g_cordic
		always_ff @(posedge clk) begin
			if (en[k+2]) begin
				for (int r = 0; r < 2; r++) begin
					cor_s[k+2][r] <= cordic_step(cordic_step(cor_s[k+1][r], 2*k), 2*k+1);
					quad_s[k+2][r] <= quad_s[k+1][r];
					w_s[k+2][r]    <= w_s[k+1][r];
					h_s[k+2][r]    <= h_s[k+1][r];
				end
				dx_s[k+2] <= dx_s[k+1];
				dy_s[k+2] <= dy_s[k+1];
			end
		end
	end

	// Trig stage: round, saturate, apply quadrant
	sincos_t sc_s10 [2];
	size_t   w_s10  [2];
	size_t   h_s10  [2];
	diff_t   dx_s10;
	diff_t   dy_s10;

	always_ff @(posedge clk) begin
		if (en[S_TRIG]) begin
			for (int r = 0; r < 2; r++) begin
				sc_s10[r] <= apply_quad(quad_s[CORD_STG+1][r],
					to_q15(cor_s[CORD_STG+1][r].x), to_q15(cor_s[CORD_STG+1][r].y));
				w_s10[r] <= w_s[CORD_STG+1][r];
				h_s10[r] <= h_s[CORD_STG+1][r];
			end
			dx_s10 <= dx_s[CORD_STG+1];
			dy_s10 <= dy_s[CORD_STG+1];
		end
	end

	// Product stage: axis norms, angle-difference terms, center offsets on axes
	tw_t   nrm_s11 [2];
	tw_t   e_s11;
	tw_t   f_s11;
	dk_t   dk_s11  [4];
	size_t w_s11   [2];
	size_t h_s11   [2];

	always_ff @(posedge clk) begin
		if (en[S_PROD]) begin
			for (int r = 0; r < 2; r++) begin
				nrm_s11[r] <= TW'(sc_s10[r].c) * TW'(sc_s10[r].c)
					+ TW'(sc_s10[r].s) * TW'(sc_s10[r].s);
				w_s11[r] <= w_s10[r];
				h_s11[r] <= h_s10[r];
			end
			e_s11 <= TW'(sc_s10[0].c) * TW'(sc_s10[1].c) + TW'(sc_s10[0].s) * TW'(sc_s10[1].s);
			f_s11 <= TW'(sc_s10[0].c) * TW'(sc_s10[1].s) - TW'(sc_s10[0].s) * TW'(sc_s10[1].c);
			for (int r = 0; r < 2; r++) begin
				dk_s11[2*r]   <= KW'(dx_s10) * KW'(sc_s10[r].c) + KW'(dy_s10) * KW'(sc_s10[r].s);
				dk_s11[2*r+1] <= KW'(dy_s10) * KW'(sc_s10[r].c) - KW'(dx_s10) * KW'(sc_s10[r].s);
			end
		end
	end

	// Extent stage: half-extent products of both rectangles on each axis
	logic [MW-1:0] ea_c;
	logic [MW-1:0] fa_c;
	logic [MW-1:0] na_c [2];
	logic [KW-1:0] dkm_c [4];
	ext_t          term_s12 [4][4];
	logic [KW-1:0] dkm_s12  [4];
	size_t         w_s12    [2];
	size_t         h_s12    [2];

	always_comb begin
		ea_c = e_s11[TW-1] ? MW'(-e_s11) : MW'(e_s11);
		fa_c = f_s11[TW-1] ? MW'(-f_s11) : MW'(f_s11);
		for (int r = 0; r < 2; r++)
			na_c[r] = MW'(nrm_s11[r]);
		for (int k = 0; k < 4; k++)
			dkm_c[k] = dk_s11[k][KW-1] ? KW'(-dk_s11[k]) : KW'(dk_s11[k]);
	end

	always_ff @(posedge clk) begin
		if (en[S_MAG]) begin
			// A's own edge axes
			term_s12[0][0] <= RW'(w_s11[0]) * RW'(na_c[0]);
			term_s12[0][1] <= '0;
			term_s12[0][2] <= RW'(w_s11[1]) * RW'(ea_c);
			term_s12[0][3] <= RW'(h_s11[1]) * RW'(fa_c);
			term_s12[1][0] <= RW'(h_s11[0]) * RW'(na_c[0]);
			term_s12[1][1] <= '0;
			term_s12[1][2] <= RW'(w_s11[1]) * RW'(fa_c);
			term_s12[1][3] <= RW'(h_s11[1]) * RW'(ea_c);
			// B's own edge axes
			term_s12[2][0] <= RW'(w_s11[0]) * RW'(ea_c);
			term_s12[2][1] <= RW'(h_s11[0]) * RW'(fa_c);
			term_s12[2][2] <= RW'(w_s11[1]) * RW'(na_c[1]);
			term_s12[2][3] <= '0;
			term_s12[3][0] <= RW'(w_s11[0]) * RW'(fa_c);
			term_s12[3][1] <= RW'(h_s11[0]) * RW'(ea_c);
			term_s12[3][2] <= RW'(h_s11[1]) * RW'(na_c[1]);
			term_s12[3][3] <= '0;
			dkm_s12 <= dkm_c;
			w_s12   <= w_s11;
			h_s12   <= h_s11;
		end
	end

	// Sum stage: total half-extent per axis, zero-length axes marked
	logic [SW-1:0] sum_s13  [4];
	logic [KW-1:0] dkm_s13  [4];
	logic [3:0]    skip_s13;

	always_ff @(posedge clk) begin
		if (en[S_SUM]) begin
			for (int k = 0; k < 4; k++)
				sum_s13[k] <= SW'(term_s12[k][0]) + SW'(term_s12[k][1])
					+ SW'(term_s12[k][2]) + SW'(term_s12[k][3]);
			dkm_s13     <= dkm_s12;
			skip_s13[0] <= (w_s12[0] == '0);
			skip_s13[1] <= (h_s12[0] == '0);
			skip_s13[2] <= (w_s12[1] == '0);
			skip_s13[3] <= (h_s12[1] == '0);
		end
	end

	// Compare stage: overlap unless an axis separates the two intervals
	logic [3:0] ovl_c;
	logic       coll_s14;

	always_comb begin
		for (int k = 0; k < 4; k++)
			ovl_c[k] = skip_s13[k]
				|| (CMPW'({dkm_s13[k], 15'b0}) <= CMPW'(sum_s13[k]));
	end

	always_ff @(posedge clk) begin
		if (en[NSTG])
			coll_s14 <= &ovl_c;
	end

	assign colliding = coll_s14;

	`ORT_ASSERT_NOW(a_ready_from_sink, out_ready, in_ready, "input stalled with sink ready")
	`ORT_ASSERT_NOW(a_trig_range, vld_s[S_TRIG],
		(sc_s10[0].c <= TRIG_MAX) && (sc_s10[0].c >= -TRIG_MAX) &&
		(sc_s10[1].s <= TRIG_MAX) && (sc_s10[1].s >= -TRIG_MAX),
		"trig value outside saturation range")
	`ORT_ASSERT_NEXT(a_no_phantom, !vld_s[NSTG-1] && !(out_valid && !out_ready), !out_valid,
		"result appeared without an item behind it")
	`ORT_ASSERT_NEXT(a_tail_held, out_valid && !out_ready && vld_s[NSTG-1], vld_s[NSTG-1],
		"item before output lost during stall")

endmodule

@@ tb/tb.sv @@
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CB = ort_pkg::COORD_BITS_DEF;
	localparam int AB = ort_pkg::ANGLE_BITS_DEF;
	localparam int SB = ort_pkg::SIZE_BITS;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic [CB-1:0] ax, ay;
		logic [SB-1:0] aw, ah;
		logic [AB-1:0] aang;
		logic [CB-1:0] bx, by;
		logic [SB-1:0] bw, bh;
		logic [AB-1:0] bang;
	} pair_t;

	typedef struct {
		longint cx2, cy2, w, h, c, s;
	} rect_t;

	typedef struct {
		longint hi, lo;
	} wide_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic signed [CB-1:0] a_x = '0, a_y = '0, b_x = '0, b_y = '0;
	logic [SB-1:0] a_w = '0, a_h = '0, b_w = '0, b_h = '0;
	logic [AB-1:0] a_angle = '0, b_angle = '0;
	logic out_valid;
	logic out_ready = 0;
	logic colliding;

	pair_t pending_pairs[$];
	bit expected_hits[$];
	int mismatches = 0;
	int idle_cycles = 0;
	bit stim_done = 0;
	bit long_holdoff = 0;
	bit sender_wait = 0;

	longint atan_tab[16] = '{536870912, 316933406, 167458907, 85004756,
		42667331, 21354465, 10679838, 5340245, 2670163, 1335087, 667544,
		333772, 166886, 83443, 41722, 20861};

	oriented_rect_overlap_test u_top (.*);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	function automatic longint fshift(longint v, int sh);
		return v >>> sh;
	endfunction

	function automatic longint round_trig(longint v);
		longint r;
		r = fshift(v + 16384, 15);
		if (r > 32767) r = 32767;
		if (r < -32767) r = -32767;
		return r;
	endfunction

	function automatic rect_t build_rect(logic [CB-1:0] x, logic [CB-1:0] y,
			logic [SB-1:0] w, logic [SB-1:0] h, logic [AB-1:0] ang);
		rect_t r;
		longint cx, cy, z, xs, ys, c, s;
		logic [31:0] phase;
		r.w = longint'(w);
		r.h = longint'(h);
		r.cx2 = 2 * longint'($signed(x)) + r.w;
		r.cy2 = 2 * longint'($signed(y)) + r.h;
		phase = {ang, {(32-AB){1'b0}}};
		z = longint'(phase[29:0]);
		cx = 652032874;
		cy = 0;
		// rotate toward zero residual angle
		for (int i = 0; i < 16; i++) begin
			xs = fshift(cx, i);
			ys = fshift(cy, i);
			if (z >= 0) begin
				cx -= ys; cy += xs; z -= atan_tab[i];
			end else begin
				cx += ys; cy -= xs; z += atan_tab[i];
			end
		end
		c = round_trig(cx);
		s = round_trig(cy);
		case (phase[31:30])
			2'd0: begin r.c = c; r.s = s; end
			2'd1: begin r.c = -s; r.s = c; end
			2'd2: begin r.c = -c; r.s = -s; end
			default: begin r.c = s; r.s = -c; end
		endcase
		return r;
	endfunction

	function automatic bit wide_less(wide_t a, wide_t b);
		return a.hi < b.hi || (a.hi == b.hi && a.lo < b.lo);
	endfunction

	function automatic void span(rect_t r, longint ux, longint uy,
			output wide_t mn, output wide_t mx);
		longint k, dx, dy, rx, ry, t;
		wide_t p;
		k = r.cx2 * ux + r.cy2 * uy;
		for (int i = 0; i < 4; i++) begin
			dx = (i == 0 || i == 3) ? -r.w : r.w;
			dy = (i < 2) ? -r.h : r.h;
			rx = dx * r.c - dy * r.s;
			ry = dx * r.s + dy * r.c;
			t = rx * ux + ry * uy;
			p.hi = k + fshift(t, 15);
			p.lo = t & 64'h7fff;
			if (i == 0 || wide_less(p, mn)) mn = p;
			if (i == 0 || wide_less(mx, p)) mx = p;
		end
	endfunction

	function automatic bit axis_hit(rect_t a, rect_t b, longint ux, longint uy);
		wide_t amn, amx, bmn, bmx;
		span(a, ux, uy, amn, amx);
		span(b, ux, uy, bmn, bmx);
		return !(wide_less(amx, bmn) || wide_less(bmx, amn));
	endfunction

	function automatic bit predict_collision(pair_t p);
		rect_t a, b;
		bit hit;
		a = build_rect(p.ax, p.ay, p.aw, p.ah, p.aang);
		b = build_rect(p.bx, p.by, p.bw, p.bh, p.bang);
		hit = 1;
		if (a.w != 0 && !axis_hit(a, b, a.c, a.s)) hit = 0;
		if (a.h != 0 && !axis_hit(a, b, -a.s, a.c)) hit = 0;
		if (b.w != 0 && !axis_hit(a, b, b.c, b.s)) hit = 0;
		if (b.h != 0 && !axis_hit(a, b, -b.s, b.c)) hit = 0;
		return hit;
	endfunction

	function automatic logic [SB-1:0] rand_size();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return SB'($urandom);
			default: return SB'($urandom_range(0, 2000));
		endcase
	endfunction

	function automatic pair_t rand_pair();
		pair_t p;
		p.aw = rand_size(); p.ah = rand_size();
		p.bw = rand_size(); p.bh = rand_size();
		p.aang = AB'($urandom); p.bang = AB'($urandom);
		if ($urandom_range(0, 4) == 0) begin
			p.ax = CB'($urandom); p.ay = CB'($urandom);
			p.bx = CB'($urandom); p.by = CB'($urandom);
		end else begin
			// keep the pair near each other so both outcomes occur
			p.ax = CB'($urandom);
			p.ay = CB'($urandom);
			p.bx = p.ax + CB'($signed($urandom_range(0, 6000)) - 3000);
			p.by = p.ay + CB'($signed($urandom_range(0, 6000)) - 3000);
		end
		return p;
	endfunction

	// fill the request queue: directed cases then random pairs
	initial begin
		pair_t p;
		p = '0;
		pending_pairs.push_back(p);
		p.aw = 16; p.ah = 16; p.bw = 16; p.bh = 16;
		pending_pairs.push_back(p);
		p.bx = 16; pending_pairs.push_back(p);
		p.bx = 17; pending_pairs.push_back(p);
		p.bang = 16'h2000; pending_pairs.push_back(p);
		p.aang = 16'hffff; p.bang = 16'h4000; pending_pairs.push_back(p);
		p.aang = 16'h8000; p.bang = 16'hc000; pending_pairs.push_back(p);
		p = '0; p.aw = '1; p.ah = '1; p.bw = 0; p.bh = 0;
		p.bx = 24'h7fffff; p.by = 24'h7fffff; pending_pairs.push_back(p);
		p.ax = 24'h800000; p.ay = 24'h800000; pending_pairs.push_back(p);
		p = '0; p.aw = 0; p.ah = 100; p.bw = 100; p.bh = 0;
		p.bx = 50; pending_pairs.push_back(p);
		p.bx = 24'h7fffff; pending_pairs.push_back(p);
		p = '1; pending_pairs.push_back(p);
		p = '0; p.ax = '1; p.ay = '1; p.bx = '1; p.by = '1;
		p.aw = 1; p.ah = 1; p.bw = 1; p.bh = 1;
		pending_pairs.push_back(p);
		p = '0; p.aw = '1; p.ah = '1; p.bw = '1; p.bh = '1;
		p.aang = 16'h1234; p.bang = 16'hedcb; p.bx = 24'h3fffff;
		pending_pairs.push_back(p);
		repeat (1450) pending_pairs.push_back(rand_pair());
		stim_done = 1;
	end

	// drive requests in bursts, with one pause until the pipe drains
	always @(posedge clk) begin
		static int burst = 0;
		static int gap = 0;
		static int sent = 0;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_hits.push_back(predict_collision(pending_pairs.pop_front()));
				sent++;
			end
			if (!(in_valid && !in_ready)) begin
				if (sent == 600 && !sender_wait) sender_wait = 1;
				if (sender_wait && expected_hits.size() == 0) begin
					sender_wait = 0;
					sent++;
				end
				if (gap > 0) gap--;
				if (burst == 0 && gap == 0) begin
					burst = $urandom_range(1, 40);
					gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end
				if (pending_pairs.size() > (in_valid && in_ready ? 0 : 0)
						&& !sender_wait && (burst > 0) && gap == 0) begin
					in_valid <= 1;
					{a_x, a_y, a_w, a_h, a_angle, b_x, b_y, b_w, b_h, b_angle}
						<= pending_pairs[0];
					burst--;
				end else begin
					in_valid <= 0;
				end
			end
		end
	end

	// stall the receiver on its own pattern, with one long hold-off
	always @(posedge clk) begin
		static int cyc = 0;
		if (arst_n) begin
			cyc++;
			long_holdoff = (cyc >= 1200 && cyc < 1500);
			if (long_holdoff) out_ready <= 0;
			else if ((cyc / 500) % 2 == 1) out_ready <= 1;
			else out_ready <= ($urandom_range(0, 3) != 0);
		end
	end

	// compare results against the oldest prediction
	always @(posedge clk) begin
		bit want;
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
			else idle_cycles++;
			if (out_valid && out_ready) begin
				if (expected_hits.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result colliding=%0d", colliding);
				end else begin
					want = expected_hits.pop_front();
					if (colliding !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("colliding: expected %0d actual %0b", want, colliding);
					end
				end
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1;
		fork
			begin
				wait (stim_done && pending_pairs.size() == 0 && !in_valid
					&& expected_hits.size() == 0);
				repeat (DRAIN_CYCLES) @(posedge clk);
				if (mismatches == 0 && expected_hits.size() == 0)
					$display("oriented_rect_overlap_test: match");
				else
					$display("oriented_rect_overlap_test: mismatch");
			end
			begin
				wait (idle_cycles >= WATCHDOG_LIMIT);
				$display("oriented_rect_overlap_test: mismatch");
			end
		join_any
		$finish;
	end
endmodule

@@ oriented_rect_overlap_test.f @@
+incdir+sv
sv/ort_pkg.sv
sv/oriented_rect_overlap_test.sv
tb/tb.sv
